[design/sumck_pkg.sv]
// Package: types, status codes and constants for the checksum frame receiver.
`default_nettype none

package sumck_pkg;

   localparam int MAX_FRAME_LEN_DEFAULT = 32;
   localparam int MIN_FRAME_LEN         = 5;
   localparam int FRAME_LEN_W           = 6;
   localparam int BYTE_W                = 8;

   localparam logic MODE_DATA  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_SHORT    = 3'd1,
      STATUS_LONG     = 3'd2,
      STATUS_LENGTH   = 3'd3,
      STATUS_CHECKSUM = 3'd4
   } status_type;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [BYTE_W-1:0]      command;
      logic [BYTE_W-1:0]      device;
      logic [FRAME_LEN_W-1:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic advance;
      logic load;
   } step_type;

endpackage

`default_nettype wire

[design/sumck_in_stage.sv]
// Input register: holds one accepted beat until the frame checker consumes it.
`default_nettype none

module sumck_in_stage
   import sumck_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   input  wire step_type step,
   output logic          item_valid,
   output req_type       item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_ready  = !valid_ff || step.advance;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !step.advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

[design/sumck_frame_check.sv]
// Frame checker: per-byte frame state and the verdict for a closed frame.
`default_nettype none

module sumck_frame_check
   import sumck_pkg::*;
#(
   parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire req_type           item,
   input  wire logic [BYTE_W-1:0] end_marker,
   input  wire logic              out_busy,
   output step_type               step,
   output rsp_type                verdict
);

   localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);
   localparam int CMP_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_LEN);
   localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_FRAME_LEN);

   logic [CNT_W-1:0]  count_ff,    count_in;
   logic [BYTE_W-1:0] lagged_sum_ff, lagged_sum_in;
   logic [BYTE_W-1:0] prev_ff,     prev_in;
   logic [BYTE_W-1:0] command_ff,  command_in;
   logic [BYTE_W-1:0] length_ff,   length_in;
   logic [BYTE_W-1:0] device_ff,   device_in;

   logic             is_flush;
   logic             is_marker;
   logic [CNT_W-1:0] len;
   status_type       status;

   assign is_flush  = item.mode == MODE_FLUSH;
   assign is_marker = !is_flush && (item.rx_byte == end_marker);
   assign len       = count_ff + CNT_W'(1);

   assign step.load    = item_valid && is_marker && !out_busy;
   assign step.advance = item_valid && (!is_marker || !out_busy);

   always_comb begin
      if (len < MIN_CNT) begin
         status = STATUS_SHORT;
      end else if (len > MAX_CNT) begin
         status = STATUS_LONG;
      end else if (CMP_W'(length_ff) != CMP_W'(len)) begin
         status = STATUS_LENGTH;
      end else if (lagged_sum_ff != prev_ff) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_OK;
      end
   end

   assign verdict.status       = status;
   assign verdict.command      = command_ff;
   assign verdict.device       = device_ff;
   assign verdict.frame_length = FRAME_LEN_W'(len);

   always_comb begin
      count_in      = count_ff;
      lagged_sum_in = lagged_sum_ff;
      prev_in       = prev_ff;
      command_in    = command_ff;
      length_in     = length_ff;
      device_in     = device_ff;
      if (step.advance) begin
         if (is_flush || is_marker) begin
            count_in      = '0;
            lagged_sum_in = '0;
            prev_in       = '0;
            command_in    = '0;
            length_in     = '0;
            device_in     = '0;
         end else begin
            if (count_ff == CNT_W'(0)) begin
               command_in = item.rx_byte;
            end
            if (count_ff == CNT_W'(1)) begin
               length_in = item.rx_byte;
            end
            if (count_ff == CNT_W'(2)) begin
               device_in = item.rx_byte;
            end
            lagged_sum_in = lagged_sum_ff + prev_ff;
            prev_in       = item.rx_byte;
            if (count_ff < MAX_CNT) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         lagged_sum_ff <= '0;
         prev_ff       <= '0;
         command_ff    <= '0;
         length_ff     <= '0;
         device_ff     <= '0;
      end else begin
         count_ff      <= count_in;
         lagged_sum_ff <= lagged_sum_in;
         prev_ff       <= prev_in;
         command_ff    <= command_in;
         length_ff     <= length_in;
         device_ff     <= device_in;
      end
   end

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("byte count above maximum frame length");

   load_advances_a: assert property (@(posedge clock) disable iff (reset)
      step.load |-> step.advance)
      else $error("verdict loaded without consuming the beat");

   flush_clears_a: assert property (@(posedge clock) disable iff (reset)
      (step.advance && is_flush) |=> (count_ff == '0 && lagged_sum_ff == '0))
      else $error("flush left frame state behind");

   ok_length_a: assert property (@(posedge clock) disable iff (reset)
      (step.load && status == STATUS_OK) |-> (len >= MIN_CNT && len <= MAX_CNT))
      else $error("ok verdict with out-of-range length");

endmodule

`default_nettype wire

[design/sumck_out_stage.sv]
// Result register: holds one verdict beat until the consumer takes it.
`default_nettype none

module sumck_out_stage
   import sumck_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step,
   input  wire rsp_type  verdict,
   output logic          out_busy,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_busy  = valid_ff && !rsp_ready;
   assign valid_in  = step.load || out_busy;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.load) begin
         data_ff <= verdict;
      end
   end

endmodule

`default_nettype wire

[design/sum_checksum_frame_receiver.sv]
// Top level: delimited frame receiver with an 8-bit sum checksum verdict.
//
// Takes one received byte (or a flush) per beat and returns one verdict beat
// for every byte equal to the end marker. Sustained rate is one beat per
// cycle while no marker beat waits on a busy result register. A marker beat
// passes through the input register and its verdict is then held in the
// result register. Frame state advances once per beat in a single small add
// and compare. A verdict that waits on rsp_ready stalls only a following
// marker beat; ordinary data bytes and flushes keep flowing. end_marker is
// written through csr_write_enable; the user must write it only while the
// block is idle, the block itself does not enforce this.
`default_nettype none

module sum_checksum_frame_receiver
   import sumck_pkg::*;
#(
   parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [BYTE_W-1:0] csr_write_data
);

   logic [BYTE_W-1:0] end_marker_ff;
   logic [BYTE_W-1:0] end_marker_in;
   step_type          step;
   logic              item_valid;
   req_type           item;
   logic              out_busy;
   rsp_type           verdict;

   assign end_marker_in = csr_write_enable ? csr_write_data : end_marker_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff <= '0;
      end else begin
         end_marker_ff <= end_marker_in;
      end
   end

   sumck_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   sumck_frame_check #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_frame_check (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .end_marker (end_marker_ff),
      .out_busy   (out_busy),
      .step       (step),
      .verdict    (verdict)
   );

   sumck_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .verdict   (verdict),
      .out_busy  (out_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[bench/frame_verdict_checker.sv]
// Checker: follows the beat, verdict and register ports, predicts frame verdicts and compares.
module frame_verdict_checker
   import sumck_pkg::*;
#(
   parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              csr_write_enable,
   input  logic [BYTE_W-1:0] csr_write_data,
   output int                failures,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [BYTE_W-1:0] end_marker;
   int                rx_count;
   logic [BYTE_W-1:0] run_sum;
   logic [BYTE_W-1:0] last_byte;
   logic [BYTE_W-1:0] cmd_byte;
   logic [BYTE_W-1:0] len_byte;
   logic [BYTE_W-1:0] dev_byte;
   rsp_type           verdict_q[$];
   int                fail_count = 0;

   initial begin
      failures = 0;
      outstanding = 0;
   end

   task automatic clear_frame();
      rx_count  = 0;
      run_sum   = '0;
      last_byte = '0;
      cmd_byte  = '0;
      len_byte  = '0;
      dev_byte  = '0;
   endtask

   task automatic track_beat(input req_type beat);
      rsp_type verdict;
      int      close_len;
      if (beat.mode == MODE_FLUSH) begin
         clear_frame();
      end else if (beat.rx_byte != end_marker) begin
         case (rx_count)
            0: cmd_byte = beat.rx_byte;
            1: len_byte = beat.rx_byte;
            2: dev_byte = beat.rx_byte;
            default: ;
         endcase
         run_sum = run_sum + last_byte;
         last_byte = beat.rx_byte;
         if (rx_count < MAX_FRAME_LEN) rx_count++;
      end else begin
         close_len = rx_count + 1;
         if (close_len < MIN_FRAME_LEN) verdict.status = STATUS_SHORT;
         else if (close_len > MAX_FRAME_LEN) verdict.status = STATUS_LONG;
         else if (len_byte != close_len) verdict.status = STATUS_LENGTH;
         else if (run_sum != last_byte) verdict.status = STATUS_CHECKSUM;
         else verdict.status = STATUS_OK;
         verdict.command      = cmd_byte;
         verdict.device       = dev_byte;
         verdict.frame_length = FRAME_LEN_W'(close_len);
         verdict_q.push_back(verdict);
         clear_frame();
      end
   endtask

   task automatic check_verdict(input rsp_type seen);
      rsp_type want;
      if (verdict_q.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: verdict with none pending: status=%0d cmd=%02h dev=%02h len=%0d",
                     $time, seen.status, seen.command, seen.device, seen.frame_length);
      end else begin
         want = verdict_q.pop_front();
         if (seen.status !== want.status || seen.command !== want.command ||
             seen.device !== want.device || seen.frame_length !== want.frame_length) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display({"%0t: verdict mismatch: ",
                         "expected status=%0d cmd=%02h dev=%02h len=%0d, ",
                         "got status=%0d cmd=%02h dev=%02h len=%0d"},
                        $time, want.status, want.command, want.device, want.frame_length,
                        seen.status, seen.command, seen.device, seen.frame_length);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         end_marker = '0;
         clear_frame();
         verdict_q.delete();
      end else begin
         if (csr_write_enable) end_marker = csr_write_data;
         if (rsp_valid && rsp_ready) check_verdict(rsp_data);
         if (req_valid && req_ready) track_beat(req_data);
      end
      failures    <= fail_count;
      outstanding <= verdict_q.size();
   end

endmodule

[bench/tb_top.sv]
// Testbench top: drives frames, flushes and marker writes into the receiver and gives the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sumck_pkg::*;

   localparam int MAX_FRAME_LEN  = MAX_FRAME_LEN_DEFAULT;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_BEATS    = 320;
   localparam int SETTLE_CYCLES  = 4;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_write_enable;
   logic [BYTE_W-1:0] csr_write_data;

   int                failures;
   int                outstanding;
   int                quiet_cycles = 0;
   int                beats_sent = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   logic              pressure_on = 1'b0;
   logic [BYTE_W-1:0] cur_marker = '0;

   sum_checksum_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_verdict_checker #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[sum_checksum_frame_receiver] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_on && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [BYTE_W-1:0] other_byte();
      logic [BYTE_W-1:0] value;
      value = BYTE_W'($urandom_range(255));
      if (value == cur_marker) value = value + 8'd1 + BYTE_W'($urandom_range(254));
      return value;
   endfunction

   task automatic send_beat(input logic mode, input logic [BYTE_W-1:0] value);
      req_type beat;
      beat.mode    = mode;
      beat.rx_byte = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_frame(input bit bad_sum, input bit bad_len);
      logic [BYTE_W-1:0] body [0:MAX_FRAME_LEN-1];
      logic [BYTE_W-1:0] sum;
      int                flen;
      int                tries;
      bit                clash;
      tries = 0;
      do begin
         flen  = $urandom_range(MAX_FRAME_LEN, MIN_FRAME_LEN);
         sum   = '0;
         clash = 1'b0;
         for (int i = 0; i < flen - 2; i++) begin
            body[i] = BYTE_W'($urandom_range(255));
            if (i == 1)
               body[i] = bad_len ? BYTE_W'(flen + $urandom_range(255, 1)) : BYTE_W'(flen);
            sum = sum + body[i];
         end
         body[flen-2] = bad_sum ? sum + BYTE_W'($urandom_range(255, 1)) : sum;
         for (int i = 0; i < flen - 1; i++)
            if (body[i] == cur_marker) clash = 1'b1;
         tries++;
      end while (clash && tries < 32);
      for (int i = 0; i < flen - 1; i++) send_beat(MODE_DATA, body[i]);
      send_beat(MODE_DATA, cur_marker);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [BYTE_W-1:0] next_marker;
      int                pick;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // marker is zero out of reset
      send_beat(MODE_DATA, 8'h00);
      send_beat(MODE_FLUSH, 8'h00);
      send_beat(MODE_DATA, 8'hFF); send_beat(MODE_DATA, 8'h05); send_beat(MODE_DATA, 8'h01);
      send_beat(MODE_DATA, 8'h05); send_beat(MODE_DATA, 8'h00);
      send_beat(MODE_DATA, 8'h10); send_beat(MODE_DATA, 8'h05); send_beat(MODE_DATA, 8'h20);
      send_beat(MODE_DATA, 8'h36); send_beat(MODE_DATA, 8'h00);
      send_beat(MODE_DATA, 8'h10); send_beat(MODE_DATA, 8'h06); send_beat(MODE_DATA, 8'h20);
      send_beat(MODE_DATA, 8'h36); send_beat(MODE_DATA, 8'h00);
      send_beat(MODE_DATA, 8'h11); send_beat(MODE_DATA, 8'h22); send_beat(MODE_FLUSH, 8'hFF);
      send_beat(MODE_DATA, 8'h33); send_beat(MODE_DATA, 8'h00);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         case (phase)
            0: next_marker = 8'hFF;
            1: next_marker = 8'h00;
            2: next_marker = BYTE_W'($urandom_range(255));
            3: next_marker = 8'h0A;
            4: next_marker = 8'h7E;
            default: next_marker = 8'h05;
         endcase
         csr_write_enable <= 1'b1;
         csr_write_data   <= next_marker;
         cur_marker = next_marker;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         if (phase == 4) pressure_on <= 1'b1;
         beats_sent = 0;
         while (beats_sent < PHASE_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               send_frame(1'b0, 1'b0);
            end else if (pick < 63) begin
               send_frame(1'b1, 1'b0);
            end else if (pick < 70) begin
               send_frame(1'b0, 1'b1);
            end else if (pick < 76) begin
               repeat ($urandom_range(MAX_FRAME_LEN + 8, MAX_FRAME_LEN - 1))
                  send_beat(MODE_DATA, other_byte());
               send_beat(MODE_DATA, cur_marker);
            end else if (pick < 84) begin
               repeat ($urandom_range(3)) send_beat(MODE_DATA, other_byte());
               send_beat(MODE_DATA, cur_marker);
            end else if (pick < 91) begin
               repeat ($urandom_range(12)) send_beat(MODE_DATA, other_byte());
               send_beat(MODE_FLUSH, BYTE_W'($urandom_range(255)));
            end else begin
               repeat ($urandom_range(8, 1)) send_beat(MODE_DATA, BYTE_W'($urandom_range(255)));
               if ($urandom_range(1)) send_beat(MODE_FLUSH, BYTE_W'($urandom_range(255)));
            end
         end
      end
      settle();

      if (failures == 0 && outstanding == 0)
         $display("[sum_checksum_frame_receiver] OK");
      else
         $display("[sum_checksum_frame_receiver] ERROR");
      $finish;
   end

endmodule
